>>> hw/rtl/bbce_pkg.sv
package bbce_pkg;

    // default build limits
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_MAX_HALF   = 7;

    // pixel word: chan0 in the low byte
    localparam int PIX_W = 24;
    localparam int CH_W  = 8;
    localparam int N_CH  = 3;

    // wide enough for a slot index or a window side at the largest MAX_HALF
    localparam int SLOT_BITS = 5;

    // configuration register indexes
    localparam logic [1:0] CFG_HALF_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic [2:0]  RST_HALF_WIDTH   = 3'd1;
    localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd480;

    // per-read lane selection, shared by all lanes
    typedef struct packed {
        logic                 rd_en;
        logic [SLOT_BITS-1:0] slot_r0;
        logic [SLOT_BITS-1:0] nrows;
        logic [SLOT_BITS-1:0] k;
        logic                 excl_en;
        logic [SLOT_BITS-1:0] excl_slot;
    } lane_sel_t;

endpackage

>>> hw/rtl/bbce_lane.sv
module bbce_lane #(
    parameter int LANE  = 0,
    parameter int DEPTH = 2048
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  logic [bbce_pkg::PIX_W-1:0] wr_data,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    input  bbce_pkg::lane_sel_t       sel,
    output logic [bbce_pkg::PIX_W-1:0] lane_data
);
    import bbce_pkg::*;

    localparam logic [SLOT_BITS:0] LANE_ID = (SLOT_BITS + 1)'(LANE);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] data_reg;
    logic             incl_reg;
    logic             incl_next;
    logic [SLOT_BITS:0] row_dist;

    // distance of this store row from the window's top row, mod k
    always_comb
    begin
        if (LANE_ID >= {1'b0, sel.slot_r0})
        begin
            row_dist = LANE_ID - {1'b0, sel.slot_r0};
        end
        else
        begin
            row_dist = LANE_ID + {1'b0, sel.k} - {1'b0, sel.slot_r0};
        end
        incl_next = (LANE_ID < {1'b0, sel.k}) && (row_dist < {1'b0, sel.nrows})
                    && !(sel.excl_en && ({1'b0, sel.excl_slot} == LANE_ID));
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (sel.rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            incl_reg <= 1'b0;
        end
        else if (sel.rd_en)
        begin
            incl_reg <= incl_next;
        end
    end

    assign lane_data = incl_reg ? data_reg : '0;

endmodule

>>> hw/rtl/bbce_merge.sv
module bbce_merge #(
    parameter int NB   = 15,
    parameter int SUMW = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [bbce_pkg::PIX_W-1:0] lane_data [NB],
    input  logic                       acc_clr,
    input  logic                       acc_en,
    output logic [SUMW-1:0]            acc [bbce_pkg::N_CH]
);
    import bbce_pkg::*;

    logic [SUMW-1:0] acc_reg  [N_CH];
    logic [SUMW-1:0] col_sum  [N_CH];

    // column sum across lanes, one per channel
    always_comb
    begin
        for (int ch = 0; ch < N_CH; ch++)
        begin
            col_sum[ch] = '0;
            for (int l = 0; l < NB; l++)
            begin
                col_sum[ch] = col_sum[ch] + SUMW'(lane_data[l][ch*CH_W +: CH_W]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int ch = 0; ch < N_CH; ch++)
            begin
                acc_reg[ch] <= '0;
            end
        end
        else if (acc_clr)
        begin
            for (int ch = 0; ch < N_CH; ch++)
            begin
                acc_reg[ch] <= '0;
            end
        end
        else if (acc_en)
        begin
            for (int ch = 0; ch < N_CH; ch++)
            begin
                acc_reg[ch] <= acc_reg[ch] + col_sum[ch];
            end
        end
    end

    assign acc = acc_reg;

endmodule

>>> hw/rtl/bbce_div.sv
module bbce_div #(
    parameter int SUMW = 16,
    parameter int DVW  = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [SUMW-1:0]         dividend [bbce_pkg::N_CH],
    input  logic [DVW-1:0]          divisor,
    output logic                    done,
    output logic [bbce_pkg::CH_W-1:0] quotient [bbce_pkg::N_CH]
);
    import bbce_pkg::*;

    localparam int CNTW = $clog2(SUMW + 1);

    logic [SUMW-1:0] q_reg   [N_CH];
    logic [DVW-1:0]  rem_reg [N_CH];
    logic [CNTW-1:0] cnt_reg;
    logic            done_reg;
    logic [DVW:0]    trial   [N_CH];

    always_comb
    begin
        for (int ch = 0; ch < N_CH; ch++)
        begin
            trial[ch] = {rem_reg[ch], q_reg[ch][SUMW-1]};
        end
    end

    // restoring division, one quotient bit per cycle on all channels
    always_ff @(posedge clk)
    begin
        for (int ch = 0; ch < N_CH; ch++)
        begin
            if (start)
            begin
                q_reg[ch]   <= dividend[ch];
                rem_reg[ch] <= '0;
            end
            else if (cnt_reg != '0)
            begin
                if (trial[ch] >= {1'b0, divisor})
                begin
                    rem_reg[ch] <= DVW'(trial[ch] - {1'b0, divisor});
                    q_reg[ch]   <= {q_reg[ch][SUMW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[ch] <= trial[ch][DVW-1:0];
                    q_reg[ch]   <= {q_reg[ch][SUMW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNTW'(1));
            if (start)
            begin
                cnt_reg <= CNTW'(SUMW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNTW'(1);
            end
        end
    end

    assign done = done_reg;
    always_comb
    begin
        for (int ch = 0; ch < N_CH; ch++)
        begin
            quotient[ch] = q_reg[ch][CH_W-1:0];
        end
    end

endmodule

>>> hw/rtl/box_blur_center_excluded.sv
// Streaming three-channel box blur. Pixels of a frame enter in raster order on s_*, followed by
// half_width*image_width+half_width flush requests (s_tuser=1); from then on each input request
// yields one blurred pixel on m_*, in raster order, m_tlast marking the frame's last pixel.
// Interior pixels get the truncated mean of the (2h+1)^2 window without its center, border
// pixels the truncated mean of the window clipped to the frame, center included. Registers
// (cfg_index 0: half_width, 1: image_width, 2: image_height) must be written by the user only
// while idle, which the block does not enforce, and such writes restart the frame. The line
// store is 2*MAX_HALF+1 row banks, one per lane; a request that emits reads one window column
// per cycle across all lanes, then a 3-channel restoring divider of SUMW bits (16 at default
// limits) runs one bit per cycle; a request before the output lag only fills the line store.
// A new request is taken while the previous result still waits on m_*.
module box_blur_center_excluded #(
    parameter int MAX_WIDTH  = bbce_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bbce_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_HALF   = bbce_pkg::DEF_MAX_HALF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // in_chan0 [7:0], in_chan1 [15:8], in_chan2 [23:16]
    input  logic        s_tuser,   // flush
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_chan0 [7:0], out_chan1 [15:8], out_chan2 [23:16]
    output logic        m_tlast    // frame_last
);
    import bbce_pkg::*;

    localparam int NB   = 2 * MAX_HALF + 1;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int HTW  = $clog2(MAX_HEIGHT + 1);
    localparam int HW   = $clog2(MAX_HALF + 1);
    localparam int SW   = $clog2(NB);
    localparam int KW   = $clog2(NB + 1);
    localparam int ICW  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_HALF * MAX_WIDTH + MAX_HALF + 1);
    localparam int SUMW = $clog2(NB * NB * 255 + 1);
    localparam int DVW  = $clog2(NB * NB + 1);
    localparam int XW   = HTW + 1;   // room for row+h and col+h

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SETUP = 7'b0000010,
        S_READ  = 7'b0000100,
        S_DRAIN = 7'b0001000,
        S_START = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [2:0]  half_width_reg;
    logic [11:0] image_width_reg;
    logic [12:0] image_height_reg;

    // clamped working values
    logic [HW-1:0]  h;
    logic [WW-1:0]  w;
    logic [HTW-1:0] ht;
    logic [KW-1:0]  k;
    logic [ICW-1:0] lag;

    always_comb
    begin
        if (half_width_reg == '0)
            h = HW'(1);
        else if (int'(half_width_reg) > MAX_HALF)
            h = HW'(MAX_HALF);
        else
            h = HW'(half_width_reg);

        if (image_width_reg == '0)
            w = WW'(1);
        else if (int'(image_width_reg) > MAX_WIDTH)
            w = WW'(MAX_WIDTH);
        else
            w = WW'(image_width_reg);

        if (image_height_reg == '0)
            ht = HTW'(1);
        else if (int'(image_height_reg) > MAX_HEIGHT)
            ht = HTW'(MAX_HEIGHT);
        else
            ht = HTW'(image_height_reg);

        k   = KW'({h, 1'b1});
        lag = ICW'(h) * ICW'(w) + ICW'(h);
    end

    // input and output position counters
    logic [ICW-1:0] item_count_reg;
    logic [HTW-1:0] in_row_reg;
    logic [CW-1:0]  in_col_reg;
    logic [SW-1:0]  in_slot_reg;
    logic [RW-1:0]  out_row_reg;
    logic [CW-1:0]  out_col_reg;
    logic [SW-1:0]  out_slot_reg;

    // window of the current output pixel
    logic [CW-1:0]  cc_reg;
    logic [CW-1:0]  c1_reg;
    logic           interior_reg;
    logic [SW-1:0]  slot_r0_reg;
    logic [KW-1:0]  nrows_reg;
    logic [DVW-1:0] divisor_reg;
    logic           rd_v_reg;

    // output register
    logic           m_tvalid_reg;
    logic [23:0]    m_tdata_reg;
    logic           m_tlast_reg;

    logic in_acc;
    logic cfg_acc;
    logic out_load;
    logic frame_end;
    logic in_col_wrap;
    logic out_col_wrap;

    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign out_load  = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);
    assign frame_end = (XW'(out_row_reg) + XW'(1) == XW'(ht))
                       && (WW'(out_col_reg) + WW'(1) == w);
    assign in_col_wrap  = (WW'(in_col_reg) + WW'(1) == w);
    assign out_col_wrap = (WW'(out_col_reg) + WW'(1) == w);

    // window setup, evaluated from the output position
    logic [XW-1:0]  rx, cx, hx;
    logic           win_interior;
    logic [RW-1:0]  win_r0, win_r1;
    logic [CW-1:0]  win_c0, win_c1;
    logic [KW-1:0]  win_nrows, win_ncols;
    logic [HW-1:0]  win_dr;
    logic [SW-1:0]  win_slot_r0;
    logic [DVW-1:0] win_div;

    always_comb
    begin
        rx = XW'(out_row_reg);
        cx = XW'(out_col_reg);
        hx = XW'(h);
        win_interior = (rx >= hx) && (cx >= hx) && (rx + hx < XW'(ht)) && (cx + hx < XW'(w));
        win_r0 = (rx >= hx) ? RW'(rx - hx) : '0;
        win_c0 = (cx >= hx) ? CW'(cx - hx) : '0;
        win_r1 = (rx + hx < XW'(ht)) ? RW'(rx + hx) : RW'(XW'(ht) - XW'(1));
        win_c1 = (cx + hx < XW'(w)) ? CW'(cx + hx) : CW'(XW'(w) - XW'(1));
        win_nrows = KW'(XW'(win_r1) - XW'(win_r0) + XW'(1));
        win_ncols = KW'(XW'(win_c1) - XW'(win_c0) + XW'(1));
        win_dr = HW'(out_row_reg - win_r0);
        // slot of the top window row: out_slot - (r - r0), mod k
        if (KW'(out_slot_reg) >= KW'(win_dr))
            win_slot_r0 = SW'(KW'(out_slot_reg) - KW'(win_dr));
        else
            win_slot_r0 = SW'(KW'(out_slot_reg) + k - KW'(win_dr));
        if (win_interior)
            win_div = DVW'(DVW'(k) * DVW'(k) - DVW'(1));
        else
            win_div = DVW'(DVW'(win_nrows) * DVW'(win_ncols));
    end

    // state machine
    logic div_done;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (item_count_reg >= lag))
                    state_next = S_SETUP;
            end
            S_SETUP: state_next = S_READ;
            S_READ:
            begin
                if (cc_reg == c1_reg)
                    state_next = S_DRAIN;
            end
            S_DRAIN: state_next = S_START;
            S_START: state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            half_width_reg   <= RST_HALF_WIDTH;
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            item_count_reg   <= '0;
            in_row_reg       <= '0;
            in_col_reg       <= '0;
            in_slot_reg      <= '0;
            out_row_reg      <= '0;
            out_col_reg      <= '0;
            out_slot_reg     <= '0;
            rd_v_reg         <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= (state_reg == S_READ);

            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            if (cfg_acc)
            begin
                case (cfg_index)
                    CFG_HALF_WIDTH:   half_width_reg   <= cfg_data[2:0];
                    CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[11:0];
                    CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[12:0];
                    default: ;
                endcase
                // a write to any of the three registers restarts the frame
                if (cfg_index == CFG_HALF_WIDTH || cfg_index == CFG_IMAGE_WIDTH
                    || cfg_index == CFG_IMAGE_HEIGHT)
                begin
                    item_count_reg <= '0;
                    in_row_reg     <= '0;
                    in_col_reg     <= '0;
                    in_slot_reg    <= '0;
                    out_row_reg    <= '0;
                    out_col_reg    <= '0;
                    out_slot_reg   <= '0;
                end
            end
            else if (in_acc)
            begin
                item_count_reg <= item_count_reg + ICW'(1);
                // input position stops at the frame end; later requests are padding
                if (in_row_reg < ht)
                begin
                    if (in_col_wrap)
                    begin
                        in_col_reg <= '0;
                        in_row_reg <= in_row_reg + HTW'(1);
                        if (KW'(in_slot_reg) + KW'(1) == k)
                            in_slot_reg <= '0;
                        else
                            in_slot_reg <= in_slot_reg + SW'(1);
                    end
                    else
                    begin
                        in_col_reg <= in_col_reg + CW'(1);
                    end
                end
            end
            else if (out_load)
            begin
                if (frame_end)
                begin
                    item_count_reg <= '0;
                    in_row_reg     <= '0;
                    in_col_reg     <= '0;
                    in_slot_reg    <= '0;
                    out_row_reg    <= '0;
                    out_col_reg    <= '0;
                    out_slot_reg   <= '0;
                end
                else if (out_col_wrap)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + RW'(1);
                    if (KW'(out_slot_reg) + KW'(1) == k)
                        out_slot_reg <= '0;
                    else
                        out_slot_reg <= out_slot_reg + SW'(1);
                end
                else
                begin
                    out_col_reg <= out_col_reg + CW'(1);
                end
            end
        end
    end

    // window registers and output payload
    logic [CH_W-1:0] quotient [N_CH];

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SETUP)
        begin
            cc_reg       <= win_c0;
            c1_reg       <= win_c1;
            interior_reg <= win_interior;
            slot_r0_reg  <= win_slot_r0;
            nrows_reg    <= win_nrows;
            divisor_reg  <= win_div;
        end
        else if (state_reg == S_READ)
        begin
            cc_reg <= cc_reg + CW'(1);
        end
        if (out_load)
        begin
            m_tdata_reg <= {quotient[2], quotient[1], quotient[0]};
            m_tlast_reg <= frame_end;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // lanes: one row bank each
    lane_sel_t        sel;
    logic [PIX_W-1:0] wr_pix;
    logic             wr_any;
    logic [PIX_W-1:0] lane_data [NB];

    assign wr_any = in_acc && !cfg_acc && (in_row_reg < ht);
    assign wr_pix = s_tuser ? '0 : s_tdata;

    always_comb
    begin
        sel.rd_en     = (state_reg == S_READ);
        sel.slot_r0   = SLOT_BITS'(slot_r0_reg);
        sel.nrows     = SLOT_BITS'(nrows_reg);
        sel.k         = SLOT_BITS'(k);
        sel.excl_en   = interior_reg && (cc_reg == out_col_reg);
        sel.excl_slot = SLOT_BITS'(out_slot_reg);
    end

    for (genvar l = 0; l < NB; l++)
    begin : g_lane
        bbce_lane #(
            .LANE  (l),
            .DEPTH (MAX_WIDTH)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr_en     (wr_any && (KW'(in_slot_reg) == KW'(l))),
            .wr_addr   (in_col_reg),
            .wr_data   (wr_pix),
            .rd_addr   (cc_reg),
            .sel       (sel),
            .lane_data (lane_data[l])
        );
    end

    logic [SUMW-1:0] acc [N_CH];

    bbce_merge #(
        .NB   (NB),
        .SUMW (SUMW)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_data (lane_data),
        .acc_clr   (state_reg == S_SETUP),
        .acc_en    (rd_v_reg),
        .acc       (acc)
    );

    bbce_div #(
        .SUMW (SUMW),
        .DVW  (DVW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_START),
        .dividend (acc),
        .divisor  (divisor_reg),
        .done     (div_done),
        .quotient (quotient)
    );

endmodule

>>> hw/rtl/bbce_checker.sv
module bbce_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

    // a new result comes only out of a busy phase
    a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without processing");

    // once a result is loaded the input side reopens
    a_ready_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("input not reopened after result");

endmodule

bind box_blur_center_excluded bbce_checker u_bbce_checker (.*);

>>> tb/box_blur_center_excluded_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the center-excluded box blur.
// A driver pulls pixel requests from a pending queue and feeds s_*; every accepted
// request runs through a local line-store model that queues the expected blurred pixel once past the lag.
// A monitor drains m_* and checks each pixel and tlast against the oldest expectation.
// Frame geometry is only changed while the block is idle.
module box_blur_center_excluded_tb;
    import bbce_pkg::*;

    localparam int STORE_ROWS = 2 * DEF_MAX_HALF + 1;
    localparam int WATCHDOG   = 5000;   // cycles with no handshake at all
    localparam int SETTLE     = 80;     // wait before a new frame, longer than one pixel's window read and division
    localparam int LONG_STALL = 400;

    typedef struct {
        bit        flush;
        bit [23:0] data;
    } px_req_t;

    typedef struct {
        bit [23:0] pix;
        bit        last;
    } blur_px_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;      // in_chan0 [7:0], in_chan1 [15:8], in_chan2 [23:16]
    logic        s_tuser;      // flush
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;      // out_chan0 [7:0], out_chan1 [15:8], out_chan2 [23:16]
    logic        m_tlast;      // frame_last

    box_blur_center_excluded dut (.*);

    // stimulus side
    px_req_t  pending_px[$];
    blur_px_t blurred_q[$];
    int       send_idle_pct;
    int       recv_idle_pct;
    bit       stall_req;
    bit       stall_taken;
    int       stall_left;
    int       errors;
    int       px_accepted;
    int       px_checked;
    int       frames_run;
    int       quiet_cycles;

    // blur model state
    bit [23:0] line_mem [STORE_ROWS][DEF_MAX_WIDTH];
    bit [2:0]  half_raw;
    bit [11:0] width_raw;
    bit [12:0] height_raw;
    int        frame_pos;
    int        next_row;
    int        next_col;

    function automatic int clampi(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // Take one request into the line store; queue the blurred pixel once past the lag.
    function automatic void blur_accept(bit flush, bit [23:0] data);
        int h, w, ht, k, total, lag, idx, r, c, r0, r1, c0, c1, area;
        int sum0, sum1, sum2;
        bit interior;
        bit [23:0] px;
        blur_px_t e;
        h = clampi(half_raw, 1, DEF_MAX_HALF);
        w = clampi(width_raw, 1, DEF_MAX_WIDTH);
        ht = clampi(height_raw, 1, DEF_MAX_HEIGHT);
        k = 2 * h + 1;
        total = w * ht;
        lag = h * w + h;
        idx = frame_pos;
        if (idx < total)
            line_mem[(idx / w) % k][idx % w] = flush ? 24'd0 : data;
        frame_pos = idx + 1;
        if (idx < lag)
            return;
        r = next_row;
        c = next_col;
        interior = (r >= h) && (c >= h) && (r + h < ht) && (c + h < w);
        r0 = (r >= h) ? r - h : 0;
        c0 = (c >= h) ? c - h : 0;
        r1 = (r + h < ht) ? r + h : ht - 1;
        c1 = (c + h < w) ? c + h : w - 1;
        sum0 = 0;
        sum1 = 0;
        sum2 = 0;
        for (int rr = r0; rr <= r1; rr++)
            for (int cc = c0; cc <= c1; cc++)
                if (!(interior && rr == r && cc == c))
                begin
                    px = line_mem[rr % k][cc];
                    sum0 += px[7:0];
                    sum1 += px[15:8];
                    sum2 += px[23:16];
                end
        area = interior ? k * k - 1 : (r1 - r0 + 1) * (c1 - c0 + 1);
        e.pix = {8'(sum2 / area), 8'(sum1 / area), 8'(sum0 / area)};
        e.last = (r * w + c + 1 >= total);
        if (e.last)
        begin
            frame_pos = 0;
            next_row = 0;
            next_col = 0;
        end
        else if (c + 1 >= w)
        begin
            next_col = 0;
            next_row = r + 1;
        end
        else
            next_col = c + 1;
        blurred_q.push_back(e);
    endfunction

    task automatic report_mismatch(string msg);
        errors++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // input stream driver: one NBA per signal per edge
    always @(posedge clk or negedge rst_n)
    begin
        px_req_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                blur_accept(s_tuser, s_tdata);
                px_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_px.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_px.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tuser  <= nxt.flush;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // output monitor, receiver back-pressure and watchdog
    always @(posedge clk or negedge rst_n)
    begin
        blur_px_t e;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (blurred_q.size() == 0)
                    report_mismatch($sformatf("unexpected pixel %h", m_tdata));
                else
                begin
                    e = blurred_q.pop_front();
                    px_checked++;
                    if (m_tdata[7:0] !== e.pix[7:0])
                        report_mismatch($sformatf("chan0 %h exp %h", m_tdata[7:0], e.pix[7:0]));
                    if (m_tdata[15:8] !== e.pix[15:8])
                        report_mismatch($sformatf("chan1 %h exp %h", m_tdata[15:8],
                                                  e.pix[15:8]));
                    if (m_tdata[23:16] !== e.pix[23:16])
                        report_mismatch($sformatf("chan2 %h exp %h", m_tdata[23:16],
                                                  e.pix[23:16]));
                    if (m_tlast !== e.last)
                        report_mismatch($sformatf("tlast %b exp %b", m_tlast, e.last));
                end
            end
            if (stall_req && !stall_taken)
            begin
                stall_taken = 1'b1;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG)
            begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG);
                $display("TEST FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_idle();
        while (pending_px.size() > 0 || s_tvalid || blurred_q.size() > 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, int val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 13'(val);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_HALF_WIDTH:   half_raw = 3'(val);
            CFG_IMAGE_WIDTH:  width_raw = 12'(val);
            CFG_IMAGE_HEIGHT: height_raw = 13'(val);
            default: ;
        endcase
        frame_pos = 0;
        next_row = 0;
        next_col = 0;
    endtask

    // One full frame plus its flush tail. extremes picks 0/255 channels;
    // hold_mid pauses the sender at mid frame until every result is back.
    task automatic run_frame(int hr, int wr, int htr, bit extremes, int flush_pct,
                             bit hold_mid, bit long_stall, output int n_items);
        int h, w, ht, total, lag;
        px_req_t q;
        wait_idle();
        repeat (SETTLE) @(posedge clk);
        cfg_write(CFG_HALF_WIDTH, hr);
        cfg_write(CFG_IMAGE_WIDTH, wr);
        cfg_write(CFG_IMAGE_HEIGHT, htr);
        h = clampi(hr & 7, 1, DEF_MAX_HALF);
        w = clampi(wr & 12'hFFF, 1, DEF_MAX_WIDTH);
        ht = clampi(htr & 13'h1FFF, 1, DEF_MAX_HEIGHT);
        total = w * ht;
        lag = h * w + h;
        n_items = total + lag;
        if (long_stall)
            stall_req = 1'b1;
        for (int i = 0; i < n_items; i++)
        begin
            if (extremes)
                q.data = {{8{1'($urandom)}}, {8{1'($urandom)}}, {8{1'($urandom)}}};
            else
                q.data = 24'($urandom);
            // in the tail, non-flush requests are padding and must be ignored
            q.flush = (i < total) ? ($urandom_range(99) < flush_pct)
                                  : ($urandom_range(99) < 85);
            pending_px.push_back(q);
            if (hold_mid && i == n_items / 2)
                wait_idle();
        end
        frames_run++;
    endtask

    initial
    begin
        int n, rand_items;
        bit held, hold;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_HALF_WIDTH;
        cfg_data = '0;
        half_raw = RST_HALF_WIDTH;
        width_raw = RST_IMAGE_WIDTH;
        height_raw = RST_IMAGE_HEIGHT;
        frame_pos = 0;
        next_row = 0;
        next_col = 0;
        errors = 0;
        px_accepted = 0;
        px_checked = 0;
        frames_run = 0;
        stall_req = 1'b0;
        stall_taken = 1'b0;
        stall_left = 0;
        held = 1'b0;
        send_idle_pct = 21;
        recv_idle_pct = 83;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero registers clamp to a 1x1 frame, a 1-pixel-wide column,
        // a 5x5 frame with saturated channels and zero pixels from in-frame flushes
        run_frame(0, 0, 0, 1'b1, 0, 1'b0, 1'b0, n);
        run_frame(1, 1, 3, 1'b1, 0, 1'b0, 1'b0, n);
        run_frame(1, 5, 5, 1'b1, 20, 1'b0, 1'b0, n);

        // random small frames through the three idling phases
        rand_items = 0;
        while (rand_items < 1050)
        begin
            if (rand_items < 350)
            begin
                send_idle_pct = 21;
                recv_idle_pct = 83;
            end
            else if (rand_items < 700)
            begin
                send_idle_pct = 83;
                recv_idle_pct = 21;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            hold = (rand_items >= 380) && !held;
            run_frame($urandom_range(7), $urandom_range(12), $urandom_range(12),
                      ($urandom_range(3) == 0), 10, hold, (rand_items > 760), n);
            if (hold)
                held = 1'b1;
            rand_items += n;
        end

        // largest half width with a full interior window, then a narrow tall frame
        run_frame(7, 15, 15, 1'b1, 5, 1'b0, 1'b0, n);
        run_frame(2, 3, 9, 1'b0, 5, 1'b0, 1'b0, n);

        wait_idle();
        repeat (SETTLE) @(posedge clk);
        $display("Covered %0d frames, %0d input requests, %0d blurred pixels checked,",
                 frames_run, px_accepted, px_checked);
        $display("half widths 1..7 incl. zero clamp, small frames up to 15x15, stalls.");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
